// File: rtl/mhq_pkg.sv
// Shared constants and helpers of the mesh height query block.
`timescale 1ns / 1ps

package mhq_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W    = 32;
    localparam int TOL_W      = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd17;

    // Request codes
    localparam logic [1:0] OP_POINT  = 2'd0;
    localparam logic [1:0] OP_TRI    = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Datapath widths
    localparam int DIFF_W = COORD_W + 1;        // vertex difference
    localparam int D_W    = 68;                 // determinant and weight numerators
    localparam int NW_W   = 70;                 // third weight numerator
    localparam int T_W    = 86;                 // tolerance times determinant
    localparam int ACC_W  = 106;                // accumulator, height numerator
    localparam int MA_W   = 36;                 // multiplier operand A
    localparam int MB_W   = 34;                 // multiplier operand B
    localparam int PROD_W = MA_W + MB_W;
    localparam int LO_W   = 34;                 // split point of wide operands
    localparam int FRAC_W = 24;                 // tolerance scale
    localparam int CHK_W  = NW_W + FRAC_W + 2;  // weight check sum
    localparam int Q_W    = 33;                 // quotient magnitude bits

    localparam logic [COORD_W-1:0] S32_MIN = 32'h8000_0000;
    localparam logic [COORD_W-1:0] S32_MAX = 32'h7FFF_FFFF;

    function automatic logic s32_less(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

// File: rtl/mhq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mhq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mhq_div.sv
// Iterative floor division of the height numerator by the determinant, saturated to 32 bits.
`timescale 1ns / 1ps

module mhq_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [mhq_pkg::ACC_W-1:0]   i_num,
    input  logic signed [mhq_pkg::D_W-1:0]     i_den,
    output logic                               o_done,
    output logic [mhq_pkg::COORD_W-1:0]        o_quot
);
    import mhq_pkg::*;

    localparam int REM_W = D_W + Q_W;
    localparam int CNT_W6 = $clog2(Q_W + 1);

    logic [ACC_W-1:0]   un;
    logic [D_W-1:0]     ud;
    logic               ovf;
    logic [REM_W-1:0]   dv_top;
    logic               fit;
    logic [REM_W-1:0]   rem_sub;
    logic [Q_W:0]       mag;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W6-1:0]  r_cnt;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_dv;
    logic [Q_W-1:0]     r_q;
    logic               r_neg;
    logic               r_ovf;
    logic [COORD_W-1:0] r_quot;

    always_comb begin
        un     = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
        ud     = i_den[D_W-1] ? D_W'(-i_den) : D_W'(i_den);
        dv_top = {ud, {Q_W{1'b0}}};
        ovf    = un >= ACC_W'(dv_top);
        fit    = r_rem >= r_dv;
        rem_sub = r_rem - r_dv;
        mag    = {1'b0, r_q} + (Q_W+1)'(r_neg && (r_rem != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= i_num[ACC_W-1] ^ i_den[D_W-1];
                r_ovf  <= ovf;
                r_rem  <= un[REM_W-1:0];
                r_dv   <= {1'b0, ud, {(Q_W-1){1'b0}}};
                r_q    <= '0;
                r_cnt  <= ovf ? '0 : CNT_W6'(Q_W);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    // one quotient bit a cycle, divisor walks right
                    if (fit) begin
                        r_rem <= rem_sub;
                    end
                    r_q   <= {r_q[Q_W-2:0], fit};
                    r_dv  <= r_dv >> 1;
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    if (r_ovf) begin
                        r_quot <= r_neg ? S32_MIN : S32_MAX;
                    end else if (r_neg) begin
                        r_quot <= (mag > (Q_W+1)'(34'h0_8000_0000)) ? S32_MIN
                                                                   : COORD_W'(0) - mag[COORD_W-1:0];
                    end else begin
                        r_quot <= (mag > (Q_W+1)'(34'h0_7FFF_FFFF)) ? S32_MAX
                                                                   : mag[COORD_W-1:0];
                    end
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/mesh_height_max_query.sv
// Top level of the mesh height query: point store, triangle sequencer and result emitter.
// One request at a time. A point request writes the point store; a triangle runs a setup (box test,
//   determinant, tolerance product), then per stored point the weight checks and, if covered, the
//   height division (shared MAC, 33-step divider). A finish emits per point a result held until taken.
// Reset: synchronous, active low; clears control state, no memory clearing pass is needed.
`timescale 1ns / 1ps

module mesh_height_max_query (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mhq_pkg::TOL_W-1:0]          i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_op,
    input  logic signed [mhq_pkg::COORD_W-1:0] i_a_x,
    input  logic signed [mhq_pkg::COORD_W-1:0] i_a_y,
    input  logic signed [mhq_pkg::COORD_W-1:0] i_a_z,
    input  logic signed [mhq_pkg::COORD_W-1:0] i_b_x,
    input  logic signed [mhq_pkg::COORD_W-1:0] i_b_y,
    input  logic signed [mhq_pkg::COORD_W-1:0] i_b_z,
    input  logic signed [mhq_pkg::COORD_W-1:0] i_c_x,
    input  logic signed [mhq_pkg::COORD_W-1:0] i_c_y,
    input  logic signed [mhq_pkg::COORD_W-1:0] i_c_z,
    input  logic                               i_is_floor,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [mhq_pkg::IDX_W-1:0]          o_point_index,
    output logic signed [mhq_pkg::COORD_W-1:0] o_solid_height,
    output logic signed [mhq_pkg::COORD_W-1:0] o_floor_height,
    output logic                               o_solid_found,
    output logic                               o_floor_found,
    output logic                               o_all_supported,
    output logic                               o_overflowed,
    output logic                               o_last
);
    import mhq_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BOX  = 4'd1;   // bounding box reject
    localparam logic [3:0] S_MAC  = 4'd2;   // multiply-accumulate phase
    localparam logic [3:0] S_PRD  = 4'd3;   // point read in flight
    localparam logic [3:0] S_PLD  = 4'd4;   // point data arrives
    localparam logic [3:0] S_CHK  = 4'd5;   // weight tolerance checks
    localparam logic [3:0] S_DIV  = 4'd6;   // height division
    localparam logic [3:0] S_WB   = 4'd7;   // max write-back
    localparam logic [3:0] S_NEXT = 4'd8;
    localparam logic [3:0] S_ERD  = 4'd9;   // emit read in flight
    localparam logic [3:0] S_EOUT = 4'd10;
    localparam logic [3:0] S_EWT  = 4'd11;

    // MAC phases
    localparam logic [2:0] PH_D = 3'd0;     // determinant
    localparam logic [2:0] PH_T = 3'd1;     // tolerance times determinant
    localparam logic [2:0] PH_U = 3'd2;     // first weight numerator
    localparam logic [2:0] PH_V = 3'd3;     // second weight numerator
    localparam logic [2:0] PH_Z = 3'd4;     // height numerator

    logic [3:0]              r_state;
    logic [2:0]              r_ph;
    logic [2:0]              r_k;
    logic [TOL_W-1:0]        r_tol;

    // latched request
    logic [1:0]              r_op;
    logic signed [COORD_W-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_cx, r_cy, r_cz;
    logic                    r_flr;

    // query state
    logic                    r_closed;
    logic                    r_dropped;
    logic [CNT_W-1:0]        r_count;
    logic signed [COORD_W-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [MAX_POINTS-1:0]   r_solid_seen;
    logic [MAX_POINTS-1:0]   r_floor_seen;
    logic [IDX_W-1:0]        r_j;

    // arithmetic registers
    logic signed [D_W-1:0]    r_d;
    logic signed [T_W-1:0]    r_told;
    logic signed [DIFF_W-1:0] r_px, r_py;
    logic signed [D_W-1:0]    r_nu, r_nv;
    logic signed [NW_W-1:0]   r_nw;
    logic                     r_ok;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv, r_pclr, r_psh;
    logic signed [ACC_W-1:0]  r_acc;

    // output register
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_o_idx;
    logic [COORD_W-1:0]      r_o_solid, r_o_floor;
    logic                    r_o_sf, r_o_ff, r_o_all, r_o_ovf, r_o_last;

    logic                    in_acc;
    logic                    out_acc;
    logic signed [DIFF_W-1:0] e1, e2, e3, e4, f2;
    logic signed [MA_W-1:0]  ma;
    logic signed [MB_W-1:0]  mb;
    logic                    msh;
    logic [2:0]              n_steps;
    logic                    mac_issue, mac_done;
    logic signed [ACC_W-1:0] pext, n_acc;
    logic signed [NW_W-1:0]  chk_num;
    logic signed [CHK_W-1:0] chk_sum;
    logic                    chk_ok;
    logic signed [NW_W-1:0]  n_nw;
    logic                    box_miss;
    logic signed [COORD_W-1:0] tmin_x, tmax_x, tmin_y, tmax_y;
    logic                    store_pt;
    logic [IDX_W-1:0]        q_waddr;
    logic [2*COORD_W-1:0]    q_rdata, m_rdata, m_wdata;
    logic [COORD_W-1:0]      qx, qy, old_s, old_f, new_s, new_f, div_q;
    logic                    div_start, div_done;
    logic [MAX_POINTS-1:0]   vmask;
    logic                    all_sup;
    logic                    is_last;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Edge vectors of the latched triangle
    assign e1 = {r_by[COORD_W-1], r_by} - {r_cy[COORD_W-1], r_cy};
    assign e2 = {r_cx[COORD_W-1], r_cx} - {r_bx[COORD_W-1], r_bx};
    assign e3 = {r_cy[COORD_W-1], r_cy} - {r_ay[COORD_W-1], r_ay};
    assign e4 = {r_ax[COORD_W-1], r_ax} - {r_cx[COORD_W-1], r_cx};
    assign f2 = {r_ay[COORD_W-1], r_ay} - {r_cy[COORD_W-1], r_cy};

    // Triangle extent against the query bounding box
    always_comb begin
        tmin_x = (r_ax < r_bx) ? r_ax : r_bx;
        tmin_x = (tmin_x < r_cx) ? tmin_x : r_cx;
        tmax_x = (r_ax > r_bx) ? r_ax : r_bx;
        tmax_x = (tmax_x > r_cx) ? tmax_x : r_cx;
        tmin_y = (r_ay < r_by) ? r_ay : r_by;
        tmin_y = (tmin_y < r_cy) ? tmin_y : r_cy;
        tmax_y = (r_ay > r_by) ? r_ay : r_by;
        tmax_y = (tmax_y > r_cy) ? tmax_y : r_cy;
        box_miss = (tmax_x < r_min_x) || (tmin_x > r_max_x) ||
                   (tmax_y < r_min_y) || (tmin_y > r_max_y);
    end

    // MAC operand selection: wide operands go in as an unsigned low part
    // and a signed high part shifted up by LO_W.
    always_comb begin
        ma  = '0;
        mb  = '0;
        msh = 1'b0;
        case (r_ph)
            PH_D: begin
                if (r_k == 3'd0) begin
                    ma = MA_W'(e1);
                    mb = MB_W'(e4);
                end else begin
                    ma = MA_W'(e2);
                    mb = MB_W'(f2);
                end
            end
            PH_T: begin
                mb = {{(MB_W-TOL_W){1'b0}}, r_tol};
                if (r_k == 3'd0) begin
                    ma = {{(MA_W-LO_W){1'b0}}, r_d[LO_W-1:0]};
                end else begin
                    ma  = MA_W'($signed(r_d[D_W-1:LO_W]));
                    msh = 1'b1;
                end
            end
            PH_U: begin
                if (r_k == 3'd0) begin
                    ma = MA_W'(e1);
                    mb = MB_W'(r_px);
                end else begin
                    ma = MA_W'(e2);
                    mb = MB_W'(r_py);
                end
            end
            PH_V: begin
                if (r_k == 3'd0) begin
                    ma = MA_W'(e3);
                    mb = MB_W'(r_px);
                end else begin
                    ma = MA_W'(e4);
                    mb = MB_W'(r_py);
                end
            end
            PH_Z: begin
                case (r_k)
                    3'd0: begin
                        ma = {{(MA_W-LO_W){1'b0}}, r_nu[LO_W-1:0]};
                        mb = MB_W'(r_az);
                    end
                    3'd1: begin
                        ma  = MA_W'($signed(r_nu[D_W-1:LO_W]));
                        mb  = MB_W'(r_az);
                        msh = 1'b1;
                    end
                    3'd2: begin
                        ma = {{(MA_W-LO_W){1'b0}}, r_nv[LO_W-1:0]};
                        mb = MB_W'(r_bz);
                    end
                    3'd3: begin
                        ma  = MA_W'($signed(r_nv[D_W-1:LO_W]));
                        mb  = MB_W'(r_bz);
                        msh = 1'b1;
                    end
                    3'd4: begin
                        ma = {{(MA_W-LO_W){1'b0}}, r_nw[LO_W-1:0]};
                        mb = MB_W'(r_cz);
                    end
                    default: begin
                        ma  = r_nw[NW_W-1:LO_W];
                        mb  = MB_W'(r_cz);
                        msh = 1'b1;
                    end
                endcase
            end
            default: begin
                ma = '0;
            end
        endcase
    end

    assign n_steps   = (r_ph == PH_Z) ? 3'd6 : 3'd2;
    assign mac_issue = (r_state == S_MAC) && (r_k < n_steps);
    assign mac_done  = (r_state == S_MAC) && (r_k == n_steps) && !r_pv;

    always_comb begin
        pext  = ACC_W'(r_prod);
        n_acc = (r_pclr ? ACC_W'(0) : r_acc) + (r_psh ? (pext <<< LO_W) : pext);
    end

    // Weight accepted when num*2^24 + tol*D is zero or carries the sign of D
    always_comb begin
        case (r_k)
            3'd0:    chk_num = NW_W'(r_nu);
            3'd1:    chk_num = NW_W'(r_nv);
            default: chk_num = r_nw;
        endcase
        chk_sum = CHK_W'($signed({chk_num, {FRAC_W{1'b0}}})) + CHK_W'(r_told);
        chk_ok  = (chk_sum == '0) || (chk_sum[CHK_W-1] == r_d[D_W-1]);
    end

    assign n_nw = NW_W'(r_d) - NW_W'(r_nu) - NW_W'($signed(r_acc[D_W-1:0]));

    // Point store
    assign store_pt = in_acc && (i_op == OP_POINT) &&
                      (r_closed || (r_count < CNT_W'(MAX_POINTS)));
    assign q_waddr  = r_closed ? IDX_W'(0) : r_count[IDX_W-1:0];
    assign qx       = q_rdata[2*COORD_W-1:COORD_W];
    assign qy       = q_rdata[COORD_W-1:0];

    mhq_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (store_pt),
        .i_waddr (q_waddr),
        .i_wdata ({i_a_x, i_a_y}),
        .i_raddr (r_j),
        .o_rdata (q_rdata)
    );

    // Running maxima, read at r_j and written back at r_j
    assign old_s = m_rdata[2*COORD_W-1:COORD_W];
    assign old_f = m_rdata[COORD_W-1:0];
    assign new_s = (!r_solid_seen[r_j] || s32_less(old_s, div_q)) ? div_q : old_s;
    assign new_f = (r_flr && (!r_floor_seen[r_j] || s32_less(old_f, div_q))) ? div_q : old_f;
    assign m_wdata = {new_s, new_f};

    mhq_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_max_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WB),
        .i_waddr (r_j),
        .i_wdata (m_wdata),
        .i_raddr (r_j),
        .o_rdata (m_rdata)
    );

    assign div_start = mac_done && (r_ph == PH_Z);

    mhq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Emit helpers
    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            vmask[i] = CNT_W'(i) < r_count;
        end
        all_sup = &(r_solid_seen | ~vmask);
        is_last = (CNT_W'(r_j) + CNT_W'(1)) == r_count;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ph         <= PH_D;
            r_k          <= '0;
            r_tol        <= TOL_RESET;
            r_closed     <= 1'b1;
            r_dropped    <= 1'b0;
            r_count      <= '0;
            r_min_x      <= '0;
            r_max_x      <= '0;
            r_min_y      <= '0;
            r_max_y      <= '0;
            r_solid_seen <= '0;
            r_floor_seen <= '0;
            r_j          <= '0;
            r_pv         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end

            r_pv <= mac_issue;
            if (mac_issue) begin
                r_k <= r_k + 3'd1;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_op)
                            OP_POINT: begin
                                if (r_closed) begin
                                    // open a new query with this point
                                    r_solid_seen <= '0;
                                    r_floor_seen <= '0;
                                    r_dropped    <= 1'b0;
                                    r_count      <= CNT_W'(1);
                                    r_min_x      <= i_a_x;
                                    r_max_x      <= i_a_x;
                                    r_min_y      <= i_a_y;
                                    r_max_y      <= i_a_y;
                                    r_closed     <= 1'b0;
                                end else if (store_pt) begin
                                    r_count <= r_count + CNT_W'(1);
                                    if (i_a_x < r_min_x) r_min_x <= i_a_x;
                                    if (i_a_x > r_max_x) r_max_x <= i_a_x;
                                    if (i_a_y < r_min_y) r_min_y <= i_a_y;
                                    if (i_a_y > r_max_y) r_max_y <= i_a_y;
                                end else begin
                                    r_dropped <= 1'b1;
                                end
                            end
                            OP_TRI: begin
                                if (!r_closed) begin
                                    r_state <= S_BOX;
                                end
                            end
                            OP_FINISH: begin
                                if (!r_closed) begin
                                    r_j     <= '0;
                                    r_state <= S_ERD;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_BOX: begin
                    if (box_miss) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_ph    <= PH_D;
                        r_k     <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (mac_done) begin
                        r_k <= '0;
                        case (r_ph)
                            PH_D: begin
                                r_d <= r_acc[D_W-1:0];
                                if (r_acc == '0) begin
                                    // degenerate triangle: drop it
                                    r_state <= S_IDLE;
                                end else begin
                                    r_ph <= PH_T;
                                end
                            end
                            PH_T: begin
                                r_told  <= r_acc[T_W-1:0];
                                r_j     <= '0;
                                r_state <= S_PRD;
                            end
                            PH_U: begin
                                r_nu <= r_acc[D_W-1:0];
                                r_ph <= PH_V;
                            end
                            PH_V: begin
                                r_nv    <= r_acc[D_W-1:0];
                                r_nw    <= n_nw;
                                r_ok    <= 1'b1;
                                r_state <= S_CHK;
                            end
                            default: begin
                                r_state <= S_DIV;
                            end
                        endcase
                    end
                end
                S_PRD: begin
                    r_state <= S_PLD;
                end
                S_PLD: begin
                    r_px    <= {qx[COORD_W-1], qx} - {r_cx[COORD_W-1], r_cx};
                    r_py    <= {qy[COORD_W-1], qy} - {r_cy[COORD_W-1], r_cy};
                    r_ph    <= PH_U;
                    r_k     <= '0;
                    r_state <= S_MAC;
                end
                S_CHK: begin
                    r_ok <= r_ok && chk_ok;
                    if (r_k == 3'd2) begin
                        r_k <= '0;
                        if (r_ok && chk_ok) begin
                            r_ph    <= PH_Z;
                            r_state <= S_MAC;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_solid_seen[r_j] <= 1'b1;
                    if (r_flr) begin
                        r_floor_seen[r_j] <= 1'b1;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (is_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_j     <= r_j + IDX_W'(1);
                        r_state <= S_PRD;
                    end
                end
                S_ERD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    r_out_valid <= 1'b1;
                    r_o_idx     <= r_j;
                    r_o_solid   <= r_solid_seen[r_j] ? old_s : S32_MIN;
                    r_o_floor   <= r_floor_seen[r_j] ? old_f : S32_MIN;
                    r_o_sf      <= r_solid_seen[r_j];
                    r_o_ff      <= r_floor_seen[r_j];
                    r_o_all     <= all_sup;
                    r_o_ovf     <= r_dropped;
                    r_o_last    <= is_last;
                    r_state     <= S_EWT;
                end
                S_EWT: begin
                    // hold the result until it is taken
                    if (out_acc) begin
                        r_out_valid <= 1'b0;
                        if (r_o_last) begin
                            r_closed <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_j     <= r_j + IDX_W'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_op;
            r_ax  <= i_a_x;
            r_ay  <= i_a_y;
            r_az  <= i_a_z;
            r_bx  <= i_b_x;
            r_by  <= i_b_y;
            r_bz  <= i_b_z;
            r_cx  <= i_c_x;
            r_cy  <= i_c_y;
            r_cz  <= i_c_z;
            r_flr <= i_is_floor && (i_op == OP_TRI);
        end
        r_prod <= ma * mb;
        r_pclr <= (r_k == 3'd0);
        r_psh  <= msh;
        if (r_pv) begin
            r_acc <= n_acc;
        end
    end

    assign o_out_valid     = r_out_valid && (r_op == OP_FINISH);
    assign o_point_index   = r_o_idx;
    assign o_solid_height  = r_o_solid;
    assign o_floor_height  = r_o_floor;
    assign o_solid_found   = r_o_sf;
    assign o_floor_found   = r_o_ff;
    assign o_all_supported = r_o_all;
    assign o_overflowed    = r_o_ovf;
    assign o_last          = r_o_last;

endmodule
